### hw/rtl/pohd_pkg.sv
// ----------------------------------------------------------------------------
// pohd_pkg
// Types and constants shared by the packed-object header decoder.
// ----------------------------------------------------------------------------
package pohd_pkg;

  localparam logic [2:0] TYPE_OFS_DELTA = 3'd6;
  localparam logic [2:0] TYPE_REF_DELTA = 3'd7;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SIZE,
    PH_OFS_FIRST,
    PH_OFS_NEXT,
    PH_REF,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic       start_header;
    logic [7:0] data_byte;
  } hdr_beat_t;

  typedef struct packed {
    logic [2:0]  object_type;
    logic [63:0] object_size;
    logic [63:0] delta_offset;
    logic [7:0]  ref_byte;
    logic [4:0]  ref_index;
    logic        ref_valid;
    logic        header_done;
    logic        overflow;
    logic [31:0] running_crc;
  } res_beat_t;

  typedef struct packed {
    phase_t      phase;
    logic [2:0]  type_reg;
    logic [63:0] size_acc;
    logic [6:0]  shift_amount;
    logic [63:0] offset_acc;
    logic [4:0]  id_count;
    logic [31:0] crc_reg;
    logic        overflow_flag;
  } dec_state_t;

  localparam dec_state_t STATE_RESET = '{
    phase: PH_IDLE, type_reg: 3'd0, size_acc: 64'd0, shift_amount: 7'd0,
    offset_acc: 64'd0, id_count: 5'd0, crc_reg: 32'd0, overflow_flag: 1'b0
  };

endpackage

### hw/rtl/pohd_step.sv
// ----------------------------------------------------------------------------
// pohd_step
// Per-byte decode: next decoder state and the result beat for one header byte.
// ----------------------------------------------------------------------------
module pohd_step import pohd_pkg::*; #(
  parameter int ID_BYTES = 20
) (
  input  dec_state_t cur,
  input  hdr_beat_t  beat,
  output dec_state_t nxt,
  output res_beat_t  res
);

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = ~crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
    end
    return ~c;
  endfunction

  logic [6:0]  low7;
  logic        more;
  logic [70:0] size_sh;
  logic [63:0] ofs_inc;
  logic [5:0]  id_inc;
  logic [2:0]  new_type;
  logic        done;
  logic        rvalid;

  assign low7     = beat.data_byte[6:0];
  assign more     = beat.data_byte[7];
  assign new_type = beat.data_byte[6:4];
  assign size_sh  = 71'(low7) << cur.shift_amount;
  assign ofs_inc  = cur.offset_acc + 64'd1;
  assign id_inc   = {1'b0, cur.id_count} + 6'd1;

  always_comb begin
    nxt    = cur;
    done   = 1'b0;
    rvalid = 1'b0;
    if (beat.start_header) begin
      nxt.type_reg      = new_type;
      nxt.size_acc      = {60'd0, beat.data_byte[3:0]};
      nxt.shift_amount  = 7'd4;
      nxt.offset_acc    = 64'd0;
      nxt.id_count      = 5'd0;
      nxt.overflow_flag = 1'b0;
      nxt.crc_reg       = crc_byte(32'd0, beat.data_byte);
      if (more) begin
        nxt.phase = PH_SIZE;
      end else if (new_type == TYPE_OFS_DELTA) begin
        nxt.phase = PH_OFS_FIRST;
      end else if (new_type == TYPE_REF_DELTA) begin
        nxt.phase = PH_REF;
      end else begin
        nxt.phase = PH_DONE;
        done      = 1'b1;
      end
    end else begin
      case (cur.phase)
        PH_SIZE: begin
          nxt.crc_reg = crc_byte(cur.crc_reg, beat.data_byte);
          if (cur.shift_amount < 7'd64) begin
            nxt.size_acc     = cur.size_acc | size_sh[63:0];
            nxt.shift_amount = cur.shift_amount + 7'd7;
            if (|size_sh[70:64]) nxt.overflow_flag = 1'b1;
          end else if (|low7) begin
            nxt.overflow_flag = 1'b1;
          end
          if (!more) begin
            if (cur.type_reg == TYPE_OFS_DELTA) begin
              nxt.phase = PH_OFS_FIRST;
            end else if (cur.type_reg == TYPE_REF_DELTA) begin
              nxt.phase = PH_REF;
            end else begin
              nxt.phase = PH_DONE;
              done      = 1'b1;
            end
          end
        end
        PH_OFS_FIRST, PH_OFS_NEXT: begin
          nxt.crc_reg = crc_byte(cur.crc_reg, beat.data_byte);
          if (cur.phase == PH_OFS_FIRST) begin
            nxt.offset_acc = {57'd0, low7};
          end else begin
            if ((ofs_inc == 64'd0) || (|ofs_inc[63:57])) nxt.overflow_flag = 1'b1;
            nxt.offset_acc = {ofs_inc[56:0], low7};
          end
          if (more) begin
            nxt.phase = PH_OFS_NEXT;
          end else begin
            nxt.phase = PH_DONE;
            done      = 1'b1;
          end
        end
        PH_REF: begin
          nxt.crc_reg  = crc_byte(cur.crc_reg, beat.data_byte);
          rvalid       = 1'b1;
          nxt.id_count = id_inc[4:0];
          if (id_inc >= 6'(ID_BYTES)) begin
            nxt.phase = PH_DONE;
            done      = 1'b1;
          end
        end
        default: begin
          nxt = cur;
        end
      endcase
    end
  end

  always_comb begin
    res.object_type   = nxt.type_reg;
    res.object_size   = nxt.size_acc;
    res.delta_offset  = nxt.offset_acc;
    res.ref_byte      = rvalid ? beat.data_byte : 8'd0;
    res.ref_index     = rvalid ? cur.id_count : 5'd0;
    res.ref_valid     = rvalid;
    res.header_done   = done;
    res.overflow      = nxt.overflow_flag;
    res.running_crc   = nxt.crc_reg;
  end

endmodule

### hw/rtl/pack_object_header_decoder.sv
// ----------------------------------------------------------------------------
// pack_object_header_decoder
// Packed-object header decoder: type, size varint, delta base, running CRC-32.
// ----------------------------------------------------------------------------
// Takes one header byte per beat and returns one result beat per byte, through
// an input register and then a result register. A new byte is accepted every
// cycle unless a result stall holds it off; the rate is set by the decoder
// state loop, which updates type, size, offset, id count and CRC in one pass
// of the step logic per byte. No clearing pass after reset.
module pack_object_header_decoder import pohd_pkg::*; #(
  parameter int ID_BYTES = 20
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      hdr_valid,
  output logic      hdr_stall,
  input  hdr_beat_t hdr,
  output logic      res_valid,
  input  logic      res_stall,
  output res_beat_t res
);

  logic       s1_valid;
  hdr_beat_t  s1;
  dec_state_t state;
  dec_state_t state_next;
  res_beat_t  res_next;
  logic       advance;

  assign advance   = !res_valid || !res_stall;
  assign hdr_stall = s1_valid && !advance;

  pohd_step #(.ID_BYTES(ID_BYTES)) u_step (
    .cur  (state),
    .beat (s1),
    .nxt  (state_next),
    .res  (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!hdr_stall) begin
      s1_valid <= hdr_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (hdr_valid && !hdr_stall) begin
      s1 <= hdr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
    end else if (s1_valid && advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && advance) begin
      res <= res_next;
    end
  end

  a_ref_type: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.ref_valid |-> res.object_type == TYPE_REF_DELTA)
    else $error("id byte on a header that is not a reference delta");

  a_ref_index: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.ref_valid |-> res.ref_index < ID_BYTES)
    else $error("id byte index past the id length");

  a_state_phase: assert property (@(posedge clk) disable iff (rst)
    state.phase == PH_REF |-> state.type_reg == TYPE_REF_DELTA)
    else $error("id phase entered for a non reference-delta type");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(s1) && $stable(state))
    else $error("input register or state changed while blocked");

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the packed-object header decoder.
// ----------------------------------------------------------------------------
// Drives header bytes through the valid/stall input channel and predicts every
// result beat with a local decoder: type, size and offset varints, id bytes,
// overflow and the running CRC-32. Directed headers cover the edge cases, then
// random well-formed headers mixed with truncated ones and stray bytes run
// with random source gaps, random sink stalls and one long sink hold-off.
// ----------------------------------------------------------------------------
module tb;
  import pohd_pkg::*;

  localparam int ID_BYTES    = 20;
  localparam int LONG_HOLD   = 300;
  localparam int CYCLE_LIMIT = 500000;

  logic      clk;
  logic      rst = 1'b1;
  logic      hdr_valid = 1'b0;
  logic      hdr_stall;
  hdr_beat_t hdr = '0;
  logic      res_valid;
  logic      res_stall = 1'b0;
  res_beat_t res;

  dec_state_t hs = STATE_RESET;
  res_beat_t  expected_decodes[$];
  int         mismatches = 0;
  int         live_bytes = 0;
  int         cycle_count = 0;
  int         burst_left = 0;
  int         max_gap = 0;
  bit         stall_en = 1'b0;
  bit         hold_req = 1'b0;

  pack_object_header_decoder #(.ID_BYTES(ID_BYTES)) u_top (
    .clk       (clk),
    .rst       (rst),
    .hdr_valid (hdr_valid),
    .hdr_stall (hdr_stall),
    .hdr       (hdr),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // reflected CRC-32, register inverted around each byte
  function automatic logic [31:0] crc32_update(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = ~crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++)
      c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
    return ~c;
  endfunction

  function automatic phase_t size_end_phase(logic [2:0] ty);
    if (ty == TYPE_OFS_DELTA) return PH_OFS_FIRST;
    if (ty == TYPE_REF_DELTA) return PH_REF;
    return PH_DONE;
  endfunction

  function automatic res_beat_t decode_byte(hdr_beat_t beat);
    res_beat_t   r;
    logic [6:0]  low7;
    logic [63:0] inc;
    logic        fin;
    r = '0;
    fin = 1'b0;
    low7 = beat.data_byte[6:0];
    if (beat.start_header) begin
      hs.type_reg = beat.data_byte[6:4];
      hs.size_acc = {60'd0, beat.data_byte[3:0]};
      hs.shift_amount = 7'd4;
      hs.offset_acc = '0;
      hs.id_count = '0;
      hs.overflow_flag = 1'b0;
      hs.crc_reg = crc32_update(32'd0, beat.data_byte);
      hs.phase = beat.data_byte[7] ? PH_SIZE : size_end_phase(hs.type_reg);
      fin = (hs.phase == PH_DONE);
    end else begin
      case (hs.phase)
        PH_SIZE: begin
          hs.crc_reg = crc32_update(hs.crc_reg, beat.data_byte);
          if (hs.shift_amount < 7'd64) begin
            hs.size_acc |= 64'(low7) << hs.shift_amount;
            if (hs.shift_amount > 7'd57 && (low7 >> (64 - int'(hs.shift_amount))) != 0)
              hs.overflow_flag = 1'b1;
            hs.shift_amount += 7'd7;
          end else if (low7 != 7'd0) begin
            hs.overflow_flag = 1'b1;
          end
          if (!beat.data_byte[7]) begin
            hs.phase = size_end_phase(hs.type_reg);
            fin = (hs.phase == PH_DONE);
          end
        end
        PH_OFS_FIRST, PH_OFS_NEXT: begin
          hs.crc_reg = crc32_update(hs.crc_reg, beat.data_byte);
          if (hs.phase == PH_OFS_FIRST) begin
            hs.offset_acc = 64'(low7);
          end else begin
            inc = hs.offset_acc + 64'd1;
            if (inc == 64'd0 || inc[63:57] != 7'd0) hs.overflow_flag = 1'b1;
            hs.offset_acc = {inc[56:0], low7};
          end
          if (beat.data_byte[7]) begin
            hs.phase = PH_OFS_NEXT;
          end else begin
            hs.phase = PH_DONE;
            fin = 1'b1;
          end
        end
        PH_REF: begin
          hs.crc_reg = crc32_update(hs.crc_reg, beat.data_byte);
          r.ref_valid = 1'b1;
          r.ref_byte = beat.data_byte;
          r.ref_index = hs.id_count;
          if (int'(hs.id_count) + 1 >= ID_BYTES) begin
            hs.phase = PH_DONE;
            fin = 1'b1;
          end
          hs.id_count = hs.id_count + 5'd1;
        end
        default: ;
      endcase
    end
    r.object_type = hs.type_reg;
    r.object_size = hs.size_acc;
    r.delta_offset = hs.offset_acc;
    r.header_done = fin;
    r.overflow = hs.overflow_flag;
    r.running_crc = hs.crc_reg;
    return r;
  endfunction

  task automatic send_byte(input logic sh, input logic [7:0] data);
    hdr_beat_t beat;
    int        gap;
    beat.start_header = sh;
    beat.data_byte = data;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = (max_gap > 0) ? $urandom_range(0, max_gap) : 0;
      if (gap > 0) begin
        hdr_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    hdr_valid <= 1'b1;
    hdr <= beat;
    do @(posedge clk); while (hdr_stall);
    if (sh || !(hs.phase == PH_IDLE || hs.phase == PH_DONE)) live_bytes++;
    expected_decodes.push_back(decode_byte(beat));
  endtask

  // receiver: random stall runs, or one long hold-off on request
  initial begin
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        res_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (stall_en && $urandom_range(0, 2) == 0) begin
        res_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        res_stall <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : result_check
    res_beat_t want;
    if (!rst && res_valid && !res_stall) begin
      if (expected_decodes.size() == 0) begin
        $error("result beat with no header byte pending");
        mismatches++;
      end else begin
        want = expected_decodes.pop_front();
        check_field("object_type", 64'(want.object_type), 64'(res.object_type));
        check_field("object_size", want.object_size, res.object_size);
        check_field("delta_offset", want.delta_offset, res.delta_offset);
        check_field("ref_byte", 64'(want.ref_byte), 64'(res.ref_byte));
        check_field("ref_index", 64'(want.ref_index), 64'(res.ref_index));
        check_field("ref_valid", 64'(want.ref_valid), 64'(res.ref_valid));
        check_field("header_done", 64'(want.header_done), 64'(res.header_done));
        check_field("overflow", 64'(want.overflow), 64'(res.overflow));
        check_field("running_crc", 64'(want.running_crc), 64'(res.running_crc));
      end
    end
  end

  function automatic int varint_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(4, 11) : $urandom_range(1, 3);
  endfunction

  function automatic logic [6:0] rand_group();
    int sel;
    sel = $urandom_range(0, 5);
    if (sel == 0) return 7'h7F;
    if (sel == 1) return 7'h00;
    return 7'($urandom);
  endfunction

  // mostly complete headers; some cut short, some followed by stray bytes
  task automatic send_random_header();
    logic [7:0] hbytes[$];
    int ty, nsize, nofs, cut, k;
    ty = $urandom_range(0, 9);
    if (ty > 7) ty = ty - 2;
    nsize = varint_len();
    hbytes.push_back({nsize > 1, 3'(ty), 4'($urandom)});
    for (k = 1; k < nsize; k++) hbytes.push_back({k < nsize - 1, rand_group()});
    if (ty == TYPE_OFS_DELTA) begin
      nofs = varint_len();
      for (k = 0; k < nofs; k++) hbytes.push_back({k < nofs - 1, rand_group()});
    end
    if (ty == TYPE_REF_DELTA)
      for (k = 0; k < ID_BYTES; k++) hbytes.push_back(8'($urandom));
    cut = hbytes.size();
    if ($urandom_range(0, 9) == 0) cut = $urandom_range(1, hbytes.size());
    for (k = 0; k < cut; k++) send_byte(k == 0, hbytes[k]);
    if ($urandom_range(0, 7) == 0)
      repeat ($urandom_range(1, 3)) send_byte(1'b0, 8'($urandom));
  endtask

  task automatic test_idle_bytes();
    send_byte(1'b0, 8'hFF);
    send_byte(1'b0, 8'h00);
  endtask

  task automatic test_single_byte_headers();
    send_byte(1'b1, 8'h00);
    send_byte(1'b0, 8'h80);
    send_byte(1'b1, 8'h5A);
  endtask

  task automatic test_restart_mid_header();
    send_byte(1'b1, 8'hFF);
    send_byte(1'b1, 8'h4C);
    send_byte(1'b1, 8'hF1);
    send_byte(1'b0, 8'h00);
    send_byte(1'b0, 8'hFF);
    send_byte(1'b0, 8'h80);
    send_byte(1'b1, 8'h30);
  endtask

  task automatic test_offset_delta();
    send_byte(1'b1, 8'hE0);
    send_byte(1'b0, 8'hFF);
    send_byte(1'b0, 8'hFF);
    send_byte(1'b0, 8'h7F);
  endtask

  task automatic test_size_overflow();
    send_byte(1'b1, 8'hAF);
    repeat (9) send_byte(1'b0, 8'hFF);
    send_byte(1'b0, 8'h7F);
  endtask

  task automatic test_random_headers(input int count);
    int target;
    target = live_bytes + count;
    while (live_bytes < target) send_random_header();
  endtask

  task automatic test_back_to_back(input int count);
    max_gap = 0;
    stall_en = 1'b0;
    test_random_headers(count);
  endtask

  task automatic test_receiver_hold(input int count);
    max_gap = 0;
    hold_req = 1'b1;
    test_random_headers(count);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    max_gap = 3;
    stall_en = 1'b1;
    test_idle_bytes();
    test_single_byte_headers();
    test_restart_mid_header();
    test_offset_delta();
    test_size_overflow();
    max_gap = 6;
    test_random_headers(950);
    test_back_to_back(200);
    test_receiver_hold(80);
    max_gap = 6;
    stall_en = 1'b1;
    test_random_headers(200);
    hdr_valid <= 1'b0;
    while (expected_decodes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
